### hdl/imubc_pkg.sv
// Package for the IMU bias calibration and scaling block.
// Holds field widths, scaling constants, result kinds and lane control types.
// No dependencies; every other file of the block imports it.
package imubc_pkg;

	// Field widths.
	localparam int RAW_W      = 16;
	localparam int RES_W      = 18;
	localparam int TEMP_W     = 16;
	localparam int BIAS_W     = 17;
	localparam int SUM_W      = 24;
	localparam int SHOWN_W    = 7;
	localparam int NUM_AXES   = 6;

	// Stream word widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 136;
	localparam int OUT_FIELD_W = NUM_AXES * RES_W + TEMP_W + SHOWN_W;

	// Scaling constants.
	localparam int GRAVITY_RAW = 16384;
	localparam int TEMP_OFS_Q8 = 5376;
	localparam int GYRO_MUL    = 256;
	localparam int GYRO_DIV    = 131;
	localparam int TEMP_MUL    = 25600;
	localparam int TEMP_DIV    = 33387;

	// Latency of the constant divider, in cycles.
	localparam int DIV_LAT = 3;

	// Input command codes.
	localparam logic CMD_CONVERT = 1'b0;
	localparam logic CMD_CALIB   = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_CONV  = 2'd0,
		KIND_CALIB = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Control from the sequencer to each axis lane.
	typedef struct packed {
		logic acc;      // add the sample to the running sum
		logic bias_wr;  // load the averaged bias and clear the sum
		logic inj;      // feed the bias itself into the scaling path
	} lane_ctl_t;

endpackage

### hdl/imubc_cdiv.sv
// Pipelined signed multiply-by-constant and divide-by-constant unit.
// Computes trunc(x * MUL / DIV) toward zero with a reciprocal estimate and one correction.
// Imports imubc_pkg, whose DIV_LAT constant gives the latency it implements.
module imubc_cdiv #(
	parameter int IN_W  = 18,
	parameter int OUT_W = 18,
	parameter int MUL   = 1,
	parameter int DIV   = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [IN_W-1:0]  x,
	output logic signed [OUT_W-1:0] y
);
	import imubc_pkg::*;

	// The magnitude stays below 2**K, so the estimate is off by at most one.
	localparam int          K    = IN_W;
	localparam logic [63:0] M64  = (64'(MUL) << K) / 64'(DIV);
	localparam int          M_W  = $clog2(M64 + 64'd1);
	localparam int          A_W  = IN_W + $clog2(MUL + 1);
	localparam int          P_W  = IN_W + M_W;
	localparam logic [M_W-1:0] RECIP = M_W'(M64);
	localparam logic [A_W-1:0] MUL_C = A_W'(MUL);
	localparam logic [A_W-1:0] DIV_C = A_W'(DIV);

	logic [IN_W-1:0] ax;
	logic            neg_s1, neg_s2;
	logic [A_W-1:0]  axm_s1, axm_s2;
	logic [P_W-1:0]  prod_s1;
	logic [A_W-1:0]  qe, qn;
	logic [A_W-1:0]  qe_s2, qn_s2;
	logic [A_W-1:0]  rem, q;
	logic signed [OUT_W-1:0] y_s3;

	// Magnitude of the input; the most negative value still fits unsigned.
	assign ax = x[IN_W-1] ? IN_W'(-x) : IN_W'(x);

	// Stage 1: scaled numerator and reciprocal product.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= x[IN_W-1];
			axm_s1  <= A_W'(ax) * MUL_C;
			prod_s1 <= P_W'(ax) * P_W'(RECIP);
		end
	end

	// Stage 2: quotient estimate and its product with the divisor.
	assign qe = A_W'(prod_s1 >> K);
	assign qn = qe * DIV_C;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			axm_s2 <= axm_s1;
			qe_s2  <= qe;
			qn_s2  <= qn;
		end
	end

	// Stage 3: correct the estimate by one where the remainder is too large.
	assign rem = axm_s2 - qn_s2;
	assign q   = (rem >= DIV_C) ? qe_s2 + A_W'(1) : qe_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3 <= neg_s2 ? OUT_W'(-q) : OUT_W'(q);
		end
	end

	assign y = y_s3;

endmodule

### hdl/imubc_lane.sv
// One motion axis lane: running calibration sum, stored bias and scaling path.
// Uses imubc_cdiv for the bias average and for the output scaling.
// Depends on imubc_pkg for widths and the lane control struct.
module imubc_lane #(
	parameter int CALIB_SAMPLES = 100,
	parameter int SCALE_MUL     = 1,
	parameter int SCALE_DIV     = 1,
	parameter int BIAS_OFS      = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  imubc_pkg::lane_ctl_t              ctl,
	input  logic signed [imubc_pkg::RAW_W-1:0] raw,
	output logic signed [imubc_pkg::RES_W-1:0] y
);
	import imubc_pkg::*;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [BIAS_W-1:0] bias_q;
	logic signed [BIAS_W-1:0] avg;
	logic signed [RES_W-1:0]  x;

	// Running sum; it clears when the bias is taken from it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.bias_wr) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + SUM_W'(raw);
		end
	end

	// Average of the sum, free running while the sum holds still.
	imubc_cdiv #(
		.IN_W  (SUM_W),
		.OUT_W (BIAS_W),
		.MUL   (1),
		.DIV   (CALIB_SAMPLES)
	) u_avg (
		.clk (clk),
		.en  (1'b1),
		.x   (sum_q),
		.y   (avg)
	);

	// Stored bias with the fixed offset taken off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (ctl.bias_wr) begin
			bias_q <= avg - BIAS_W'(BIAS_OFS);
		end
	end

	// Scaling input: sample minus bias, or the new bias on completion.
	assign x = ctl.inj ? RES_W'(bias_q) : RES_W'(raw) - RES_W'(bias_q);

	imubc_cdiv #(
		.IN_W  (RES_W),
		.OUT_W (RES_W),
		.MUL   (SCALE_MUL),
		.DIV   (SCALE_DIV)
	) u_scale (
		.clk (clk),
		.en  (en),
		.x   (x),
		.y   (y)
	);

endmodule

### hdl/imu_bias_calibrate_and_scale.sv
// IMU bias calibration and scaling, top level: sequencer, six axis lanes, temperature path.
// One word per cycle while the skid entry is empty; results pass the divider stages and output register.
// The word that completes a calibration run holds off input through ST_DIV and ST_INJ while
// the lane dividers form the averages; its result then enters the pipeline as usual.
// Reset clears sums, biases, sample count, sequencer and all valid flags.
// Depends on imubc_pkg, imubc_lane and imubc_cdiv.
module imu_bias_calibrate_and_scale #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_axis_tdata, low bit up: accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
	// gyro_x_raw, gyro_y_raw, gyro_z_raw.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [imubc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// s_axis_tuser: command.
	input  logic                                s_axis_tuser,
	// m_axis_tdata, low bit up: accel_x_out, accel_y_out, accel_z_out, gyro_x_out,
	// gyro_y_out, gyro_z_out, temperature_out, samples_taken, zero pad.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [imubc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// m_axis_tuser: result_kind.
	output logic [1:0]                          m_axis_tuser
);
	import imubc_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

	typedef enum logic [2:0] {
		ST_RUN = 3'b001,
		ST_DIV = 3'b010,
		ST_INJ = 3'b100
	} state_t;

	state_t            state_q;
	logic [1:0]        wait_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic              accept, complete, inj_fire, pipe_en, push, taken;
	logic              entry_v;
	kind_t             entry_kind;
	logic [SHOWN_W-1:0] entry_shown;
	lane_ctl_t         ctl;

	logic              v_s1, v_s2, v_s3;
	kind_t             kind_s1, kind_s2, kind_s3;
	logic [SHOWN_W-1:0] shown_s1, shown_s2, shown_s3;

	logic signed [RES_W-1:0]  lane_y [NUM_AXES];
	logic signed [RES_W-1:0]  res [NUM_AXES];
	logic signed [TEMP_W-1:0] temp_y, temp_res;
	logic [OUT_TDATA_W-1:0]   word;

	logic                     m_valid_q, skid_v_q;
	logic [OUT_TDATA_W-1:0]   m_data_q, skid_data_q;
	kind_t                    m_kind_q, skid_kind_q;

	// Handshake and calibration run bookkeeping.
	assign pipe_en       = !skid_v_q;
	assign s_axis_tready = pipe_en && (state_q == ST_RUN);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign count_next    = count_q + CNT_W'(1);
	assign complete      = (s_axis_tuser == CMD_CALIB) &&
	                       (count_next >= CNT_W'(CALIB_SAMPLES));
	assign inj_fire      = (state_q == ST_INJ) && pipe_en;

	assign ctl.acc     = accept && (s_axis_tuser == CMD_CALIB);
	assign ctl.bias_wr = (state_q == ST_DIV) && (wait_q == 2'(DIV_LAT));
	assign ctl.inj     = (state_q == ST_INJ);

	// Sequencer: count calibration samples, wait for the averages, then issue the completion result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			wait_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept && s_axis_tuser == CMD_CALIB) begin
						if (complete) begin
							count_q <= '0;
							wait_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							count_q <= count_next;
						end
					end
				end
				ST_DIV: begin
					if (ctl.bias_wr) begin
						state_q <= ST_INJ;
					end else begin
						wait_q <= wait_q + 2'd1;
					end
				end
				ST_INJ: begin
					if (inj_fire) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Entry tag: the completing word itself yields no result until injection.
	assign entry_v = (accept && !complete) || inj_fire;

	always_comb begin
		if (inj_fire) begin
			entry_kind  = KIND_DONE;
			entry_shown = SHOWN_W'(CALIB_SAMPLES);
		end else if (s_axis_tuser == CMD_CALIB) begin
			entry_kind  = KIND_CALIB;
			entry_shown = SHOWN_W'(count_next);
		end else begin
			entry_kind  = KIND_CONV;
			entry_shown = SHOWN_W'(count_q);
		end
	end

	// Axis lanes: accel lanes pass the difference, gyro lanes scale by 256/131.
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
		localparam int SLOT = (i < 3) ? i : i + 1;
		imubc_lane #(
			.CALIB_SAMPLES (CALIB_SAMPLES),
			.SCALE_MUL     ((i < 3) ? 1 : GYRO_MUL),
			.SCALE_DIV     ((i < 3) ? 1 : GYRO_DIV),
			.BIAS_OFS      ((i == 2) ? GRAVITY_RAW : 0)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (pipe_en),
			.ctl    (ctl),
			.raw    (s_axis_tdata[SLOT*RAW_W +: RAW_W]),
			.y      (lane_y[i])
		);
	end

	// Temperature scaling path.
	imubc_cdiv #(
		.IN_W  (TEMP_W),
		.OUT_W (TEMP_W),
		.MUL   (TEMP_MUL),
		.DIV   (TEMP_DIV)
	) u_temp (
		.clk (clk),
		.en  (pipe_en),
		.x   (s_axis_tdata[3*RAW_W +: RAW_W]),
		.y   (temp_y)
	);

	// Tag pipeline alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= entry_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s1  <= entry_kind;
			kind_s2  <= kind_s1;
			kind_s3  <= kind_s2;
			shown_s1 <= entry_shown;
			shown_s2 <= shown_s1;
			shown_s3 <= shown_s2;
		end
	end

	// Merge lane results into one output word by kind.
	always_comb begin
		for (int j = 0; j < NUM_AXES; j++) begin
			res[j] = (kind_s3 == KIND_CALIB) ? '0 : lane_y[j];
		end
		temp_res = (kind_s3 == KIND_CONV) ? temp_y + TEMP_W'(TEMP_OFS_Q8) : '0;
		word = {(OUT_TDATA_W - OUT_FIELD_W)'(0), shown_s3, temp_res,
		        res[5], res[4], res[3], res[2], res[1], res[0]};
	end

	// Output register with a skid entry behind it.
	assign push  = pipe_en && v_s3;
	assign taken = m_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (skid_v_q) begin
			if (taken) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!m_valid_q || taken) begin
				m_valid_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (taken) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (taken) begin
				m_data_q <= skid_data_q;
				m_kind_q <= skid_kind_q;
			end
		end else if (push) begin
			if (!m_valid_q || taken) begin
				m_data_q <= word;
				m_kind_q <= kind_s3;
			end else begin
				skid_data_q <= word;
				skid_kind_q <= kind_s3;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_kind_q;

	// The word that completes a run blocks input while the averages form.
	a_hold_after_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && complete) |=> !s_axis_tready)
		else $error("input accepted right after a completing calibration word");

	// The skid entry is only ever occupied behind a held output word.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> m_valid_q)
		else $error("skid entry valid while output register is empty");

	// A completion result always reports the full run length.
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_kind_q == KIND_DONE) |->
		(m_data_q[OUT_FIELD_W-1 -: SHOWN_W] == SHOWN_W'(CALIB_SAMPLES)))
		else $error("completion result with wrong sample count");

endmodule
